@@ sv/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared constants, codes and types of the counterclockwise matrix rotator.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int MRC_MAX_DIM    = 64;
    localparam int MRC_DATA_WIDTH = 32;

    localparam int SIZE_W      = 7;
    localparam int ELEM_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [0:0] OP_LOAD  = 1'b0;
    localparam logic [0:0] OP_FETCH = 1'b1;

    localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd1;

    localparam logic [1:0] CMD_WRITE     = 2'd0;
    localparam logic [1:0] CMD_READ      = 2'd1;
    localparam logic [1:0] CMD_NOT_READY = 2'd2;
    localparam logic [1:0] CMD_REJECT    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       last;
    } t_cmd_ctl;

    typedef struct packed {
        logic draining;
        logic push;
    } t_front_stat;

endpackage

@@ sv/mrc_ram.sv @@
// ----------------------------------------------------------------------------
// mrc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ sv/mrc_queue.sv @@
// ----------------------------------------------------------------------------
// mrc_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module mrc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/mrc_front.sv @@
// ----------------------------------------------------------------------------
// mrc_front
// Accepts items, classifies them against the load or drain phase and issues
// memory and status commands with row-major write and rotated read addresses.
// ----------------------------------------------------------------------------
module mrc_front #(
    parameter int MAX_DIM    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_cfg_wr,
    input  logic [mrc_pkg::SIZE_W-1:0]                           i_cfg_size,
    input  logic                                                 i_valid,
    output logic                                                 o_ready,
    input  logic [0:0]                                           i_operation,
    input  logic [mrc_pkg::ELEM_W-1:0]                           i_element,
    input  logic                                                 i_q_full,
    output mrc_pkg::t_cmd_ctl                                    o_ctl,
    output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] o_addr,
    output logic [DATA_WIDTH-1:0]                                o_data,
    output mrc_pkg::t_front_stat                                 o_stat
);

    import mrc_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int SQ_W   = 2 * DIM_W;

    logic [DIM_W-1:0]  w_side;
    logic [SQ_W-1:0]   w_square;
    logic              w_accept;
    logic              w_fin;

    logic [DIM_W-1:0]  r_side;
    logic [IDX_W-1:0]  r_side_m1;
    logic [ADDR_W-1:0] r_last_idx;
    logic              r_draining;
    logic [ADDR_W-1:0] r_load_cnt;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_addr;

    always_comb begin
        if (i_cfg_size == '0) begin
            w_side = DIM_W'(1);
        end else if (32'(i_cfg_size) > 32'(MAX_DIM)) begin
            w_side = DIM_W'(MAX_DIM);
        end else begin
            w_side = DIM_W'(i_cfg_size);
        end
        w_square = SQ_W'(w_side) * SQ_W'(w_side);
    end

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_fin    = (r_row == r_side_m1) && (r_col == r_side_m1);

    always_comb begin
        o_ctl.last = 1'b0;
        o_addr     = r_load_cnt;
        o_data     = DATA_WIDTH'(i_element);
        if (i_operation == OP_LOAD) begin
            o_ctl.kind = r_draining ? CMD_REJECT : CMD_WRITE;
        end else if (!r_draining) begin
            o_ctl.kind = CMD_NOT_READY;
        end else begin
            o_ctl.kind = CMD_READ;
            o_ctl.last = w_fin;
            o_addr     = r_addr;
        end
    end

    assign o_stat.draining = r_draining;
    assign o_stat.push     = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= DIM_W'(1);
            r_side_m1  <= '0;
            r_last_idx <= '0;
        end else if (i_cfg_wr) begin
            r_side     <= w_side;
            r_side_m1  <= IDX_W'(w_side - 1'b1);
            r_last_idx <= ADDR_W'(w_square - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_draining <= 1'b0;
            r_load_cnt <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_addr     <= '0;
        end else if (w_accept) begin
            if (i_operation == OP_LOAD && !r_draining) begin
                if (r_load_cnt == r_last_idx) begin
                    r_draining <= 1'b1;
                    r_load_cnt <= '0;
                    r_row      <= '0;
                    r_col      <= '0;
                    r_addr     <= ADDR_W'(r_side_m1);
                end else begin
                    r_load_cnt <= r_load_cnt + 1'b1;
                end
            end else if (i_operation == OP_FETCH && r_draining) begin
                if (w_fin) begin
                    r_draining <= 1'b0;
                    r_row      <= '0;
                    r_col      <= '0;
                    r_addr     <= '0;
                end else if (r_col == r_side_m1) begin
                    r_col  <= '0;
                    r_row  <= r_row + 1'b1;
                    r_addr <= ADDR_W'(r_side_m1) - ADDR_W'(r_row) - 1'b1;
                end else begin
                    r_col  <= r_col + 1'b1;
                    r_addr <= r_addr + ADDR_W'(r_side);
                end
            end
        end
    end

endmodule

@@ sv/mrc_back.sv @@
// ----------------------------------------------------------------------------
// mrc_back
// Executes queued commands against the matrix store and holds one result
// item in an output register.
// ----------------------------------------------------------------------------
module mrc_back #(
    parameter int MAX_DIM    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_empty,
    input  mrc_pkg::t_cmd_ctl                                    i_ctl,
    input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] i_addr,
    input  logic [DATA_WIDTH-1:0]                                i_data,
    output logic                                                 o_pop,
    output logic                                                 o_valid,
    input  logic                                                 i_ready,
    output logic [mrc_pkg::STATUS_W-1:0]                         o_status,
    output logic [mrc_pkg::ELEM_W-1:0]                           o_value,
    output logic                                                 o_last
);

    import mrc_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic                  w_we;
    logic                  w_re;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic                  r_pend;
    logic                  r_pend_last;

    assign o_pop = !i_empty && !r_pend && (!o_valid || i_ready);
    assign w_we  = o_pop && (i_ctl.kind == CMD_WRITE);
    assign w_re  = o_pop && (i_ctl.kind == CMD_READ);

    mrc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_addr),
        .i_wdata (i_data),
        .i_re    (w_re),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_pend      <= w_re;
            r_pend_last <= i_ctl.last;
            if (r_pend) begin
                o_valid <= 1'b1;
            end else if (o_pop && (i_ctl.kind == CMD_NOT_READY || i_ctl.kind == CMD_REJECT))
            begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            o_status <= ST_OK;
            o_value  <= ELEM_W'($signed(w_rdata));
            o_last   <= r_pend_last;
        end else if (o_pop && i_ctl.kind == CMD_NOT_READY) begin
            o_status <= ST_NOT_READY;
            o_value  <= '0;
            o_last   <= 1'b0;
        end else if (o_pop && i_ctl.kind == CMD_REJECT) begin
            o_status <= ST_REJECTED;
            o_value  <= '0;
            o_last   <= 1'b0;
        end
    end

endmodule

@@ sv/matrix_rotate_ccw_unit.sv @@
// ----------------------------------------------------------------------------
// matrix_rotate_ccw_unit
// Rotates a square matrix of programmable side length 90 degrees
// counterclockwise.
// ----------------------------------------------------------------------------
// Load items write the matrix in row-major order into the matrix store;
// once the matrix is full, each fetch item returns the next element of the
// rotated matrix in row-major order, with tlast on the final one, and the
// block returns to loading. A fetch before the matrix is full returns status
// not_ready, and a load during the drain returns status rejected. Input items
// are taken one per cycle while the four-entry command queue has room; the
// back end starts no new command while a rotated read is pending, since the
// store has a registered read port that feeds the output register. Every
// command waits while an unaccepted result holds the output register. Writing
// matrix_size restarts loading and abandons the current matrix.
// ----------------------------------------------------------------------------
module matrix_rotate_ccw_unit #(
    parameter int MAX_DIM    = mrc_pkg::MRC_MAX_DIM,
    parameter int DATA_WIDTH = mrc_pkg::MRC_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mrc_pkg::APB_AW-1:0]        paddr,
    input  logic [mrc_pkg::APB_DW-1:0]        pwdata,
    output logic [mrc_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [mrc_pkg::ELEM_W-1:0]        i_s_tdata,   // element
    input  logic [0:0]                        i_s_tuser,   // operation
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [mrc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // status, value, zero fill
    output logic                              o_m_tlast
);

    import mrc_pkg::*;

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CMD_W  = $bits(t_cmd_ctl) + ADDR_W + DATA_WIDTH;

    logic                  w_cfg_wr;
    logic [SIZE_W-1:0]     r_size;
    t_cmd_ctl              w_push_ctl;
    logic [ADDR_W-1:0]     w_push_addr;
    logic [DATA_WIDTH-1:0] w_push_data;
    t_front_stat           w_front_stat;
    logic                  w_q_full;
    logic                  w_q_empty;
    logic                  w_pop;
    logic [CMD_W-1:0]      w_q_out;
    t_cmd_ctl              w_pop_ctl;
    logic [ADDR_W-1:0]     w_pop_addr;
    logic [DATA_WIDTH-1:0] w_pop_data;
    logic [STATUS_W-1:0]   w_status;
    logic [ELEM_W-1:0]     w_value;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MATRIX_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? APB_DW'(r_size) : '0;

    mrc_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (w_cfg_wr),
        .i_cfg_size  (pwdata[SIZE_W-1:0]),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_operation (i_s_tuser),
        .i_element   (i_s_tdata),
        .i_q_full    (w_q_full),
        .o_ctl       (w_push_ctl),
        .o_addr      (w_push_addr),
        .o_data      (w_push_data),
        .o_stat      (w_front_stat)
    );

    mrc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_stat.push),
        .i_data  ({w_push_ctl, w_push_addr, w_push_data}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    assign {w_pop_ctl, w_pop_addr, w_pop_data} = w_q_out;

    mrc_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_q_empty),
        .i_ctl    (w_pop_ctl),
        .i_addr   (w_pop_addr),
        .i_data   (w_pop_data),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_status (w_status),
        .o_value  (w_value),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - ELEM_W - STATUS_W){1'b0}}, w_value, w_status};

    a_last_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[STATUS_W-1:0] == ST_OK)
        else $error("last item carries a non-ok status");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[STATUS_W-1:0] != ST_OK
            |-> o_m_tdata[ELEM_W+STATUS_W-1:STATUS_W] == '0)
        else $error("error item carries a nonzero value");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !w_front_stat.draining)
        else $error("size write did not return the block to loading");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_stat.push |-> !w_q_full || w_pop)
        else $error("command queue overflow");

endmodule

@@ test/mrc_rotate_checker.sv @@
// ----------------------------------------------------------------------------
// mrc_rotate_checker
// Watches the configuration port and both streams of the counterclockwise
// matrix rotator, predicts every result item and compares it field by field
// with what the block returns.
// ----------------------------------------------------------------------------
module mrc_rotate_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic                              i_pready,
    input  logic [mrc_pkg::APB_AW-1:0]        i_paddr,
    input  logic [mrc_pkg::APB_DW-1:0]        i_pwdata,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [mrc_pkg::ELEM_W-1:0]        i_s_tdata,   // element
    input  logic [0:0]                        i_s_tuser,   // operation
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [mrc_pkg::OUT_TDATA_W-1:0]   i_m_tdata,   // status, value, zero fill
    input  logic                              i_m_tlast,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int STORE_DEPTH = mrc_pkg::MRC_MAX_DIM * mrc_pkg::MRC_MAX_DIM;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam int VALUE_LSB   = mrc_pkg::STATUS_W;
    localparam int FILL_LSB    = mrc_pkg::STATUS_W + mrc_pkg::ELEM_W;
    localparam int FILL_W      = mrc_pkg::OUT_TDATA_W - FILL_LSB;
    localparam logic [mrc_pkg::APB_AW-1:0] SIZE_ADDR = {mrc_pkg::REG_MATRIX_SIZE, 2'b00};

    typedef struct packed {
        logic [mrc_pkg::STATUS_W-1:0] status;
        logic [mrc_pkg::ELEM_W-1:0]   value;
        logic                         last;
    } t_rot_result;

    logic [mrc_pkg::ELEM_W-1:0] matrix_copy [STORE_DEPTH];
    t_rot_result                expected_q [$];
    logic [mrc_pkg::SIZE_W-1:0] side_reg;
    int unsigned                loaded;
    int unsigned                next_row;
    int unsigned                next_col;
    bit                         draining;
    int                         fail_count = 0;

    function automatic int unsigned side_len();
        if (side_reg == '0) begin
            return 1;
        end
        if (side_reg > mrc_pkg::MRC_MAX_DIM) begin
            return mrc_pkg::MRC_MAX_DIM;
        end
        return side_reg;
    endfunction

    task automatic restart_matrix();
        loaded   = 0;
        next_row = 0;
        next_col = 0;
        draining = 1'b0;
    endtask

    task automatic predict_rotation(input logic [0:0] op, input logic [mrc_pkg::ELEM_W-1:0] elem);
        int unsigned n;
        int unsigned addr;
        t_rot_result res;
        n   = side_len();
        res = '0;
        if (op == mrc_pkg::OP_LOAD) begin
            if (draining) begin
                res.status = mrc_pkg::ST_REJECTED;
                expected_q = {expected_q, res};
            end else begin
                if (loaded < n * n) begin
                    matrix_copy[STORE_IDX_W'(loaded)] = elem;
                end
                loaded++;
                if (loaded >= n * n) begin
                    draining = 1'b1;
                    next_row = 0;
                    next_col = 0;
                end
            end
        end else if (!draining) begin
            res.status = mrc_pkg::ST_NOT_READY;
            expected_q = {expected_q, res};
        end else begin
            // Result (r,c) of the rotated matrix is input (c, n-1-r).
            addr       = next_col * n + (n - 1 - next_row);
            res.status = mrc_pkg::ST_OK;
            res.value  = matrix_copy[STORE_IDX_W'(addr)];
            res.last   = (next_row == n - 1) && (next_col == n - 1);
            if (res.last) begin
                restart_matrix();
            end else if (next_col + 1 >= n) begin
                next_col = 0;
                next_row++;
            end else begin
                next_col++;
            end
            expected_q = {expected_q, res};
        end
    endtask

    task automatic check_field(input string name, input logic [mrc_pkg::ELEM_W-1:0] want,
                               input logic [mrc_pkg::ELEM_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_rot_result want;
        if (!i_rst_n) begin
            expected_q.delete();
            side_reg = mrc_pkg::SIZE_RESET;
            restart_matrix();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected item, expected none, actual %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_m_tdata[1:0]));
                    check_field("value", want.value, i_m_tdata[VALUE_LSB +: mrc_pkg::ELEM_W]);
                    check_field("last", 32'(want.last), 32'(i_m_tlast));
                    check_field("fill", '0, 32'(i_m_tdata[FILL_LSB +: FILL_W]));
                end
            end
            // Any write of the size register abandons the matrix in progress.
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == SIZE_ADDR) begin
                side_reg = i_pwdata[mrc_pkg::SIZE_W-1:0];
                restart_matrix();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_rotation(i_s_tuser, i_s_tdata);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ test/matrix_rotate_ccw_unit_tb.sv @@
// ----------------------------------------------------------------------------
// matrix_rotate_ccw_unit_tb
// Drives the counterclockwise matrix rotator with directed and random items.
// ----------------------------------------------------------------------------
// A directed part covers the status cases, the element extremes, the size
// clamping and an abandoned matrix, and loads part of a matrix at the largest
// size. The random part runs mostly complete matrices of small sizes with
// stray items and early size writes mixed in, under four idling patterns on
// the two streams. A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module matrix_rotate_ccw_unit_tb;

    localparam int DRAIN_CYCLES     = 16;
    localparam int END_WAIT_LIMIT   = 100000;
    localparam int RANDOM_PER_PHASE = 130;
    localparam logic [mrc_pkg::APB_AW-1:0] SIZE_ADDR = {mrc_pkg::REG_MATRIX_SIZE, 2'b00};

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [mrc_pkg::APB_AW-1:0]        paddr;
    logic [mrc_pkg::APB_DW-1:0]        pwdata;
    logic [mrc_pkg::APB_DW-1:0]        prdata;
    logic                              pready;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [mrc_pkg::ELEM_W-1:0]        i_s_tdata;   // element
    logic [0:0]                        i_s_tuser;   // operation
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [mrc_pkg::OUT_TDATA_W-1:0]   o_m_tdata;   // status, value, zero fill
    logic                              o_m_tlast;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cur_side;

    matrix_rotate_ccw_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    mrc_rotate_checker u_rotate_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #10_000_000;
        $display("FAIL matrix_rotate_ccw_unit");
        $finish;
    end

    function automatic logic [mrc_pkg::ELEM_W-1:0] rand_element();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [mrc_pkg::SIZE_W-1:0] rand_size();
        if ($urandom_range(9) == 0) begin
            return '0;
        end
        return mrc_pkg::SIZE_W'($urandom_range(1, 6));
    endfunction

    task automatic send_item(input logic [0:0] op, input logic [mrc_pkg::ELEM_W-1:0] elem);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= elem;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Loads give no result, so a further wait after the last expected result lets the command queue empty.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [mrc_pkg::SIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= ($urandom & ~32'h7F) | 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (value == '0) begin
            cur_side = 1;
        end else if (value > mrc_pkg::MRC_MAX_DIM) begin
            cur_side = mrc_pkg::MRC_MAX_DIM;
        end else begin
            cur_side = value;
        end
    endtask

    initial begin
        int  phase;
        int  count;
        int  total;
        int  k;
        int  guard;
        bit  abandoned;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = mrc_pkg::OP_LOAD;
        cur_side   = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset size gives a single-element matrix.
        send_item(mrc_pkg::OP_FETCH, rand_element());
        send_item(mrc_pkg::OP_LOAD, 32'h8000_0000);
        send_item(mrc_pkg::OP_LOAD, 32'h7FFF_FFFF);
        send_item(mrc_pkg::OP_FETCH, 32'h0000_0000);

        wait_idle();
        write_size('0);
        send_item(mrc_pkg::OP_LOAD, 32'h7FFF_FFFF);
        send_item(mrc_pkg::OP_FETCH, 32'hFFFF_FFFF);

        wait_idle();
        write_size(mrc_pkg::SIZE_W'(2));
        send_item(mrc_pkg::OP_FETCH, rand_element());
        send_item(mrc_pkg::OP_LOAD, 32'hFFFF_FFFF);
        send_item(mrc_pkg::OP_LOAD, 32'h0000_0000);
        send_item(mrc_pkg::OP_LOAD, 32'h1234_5678);
        send_item(mrc_pkg::OP_LOAD, 32'h8000_0001);
        send_item(mrc_pkg::OP_LOAD, rand_element());
        for (k = 0; k < 4; k++) send_item(mrc_pkg::OP_FETCH, rand_element());

        // A size write in the middle of loading starts a fresh matrix.
        wait_idle();
        write_size(mrc_pkg::SIZE_W'(3));
        send_item(mrc_pkg::OP_LOAD, rand_element());
        send_item(mrc_pkg::OP_LOAD, rand_element());
        wait_idle();
        write_size(mrc_pkg::SIZE_W'(2));
        for (k = 0; k < 4; k++) send_item(mrc_pkg::OP_LOAD, rand_element());
        for (k = 0; k < 4; k++) send_item(mrc_pkg::OP_FETCH, rand_element());

        // The largest size, then an oversized value that clamps to it.
        wait_idle();
        write_size(mrc_pkg::SIZE_W'(mrc_pkg::MRC_MAX_DIM));
        for (k = 0; k < 5; k++) send_item(mrc_pkg::OP_LOAD, rand_element());
        send_item(mrc_pkg::OP_FETCH, rand_element());
        wait_idle();
        write_size(7'h7F);
        for (k = 0; k < 5; k++) send_item(mrc_pkg::OP_LOAD, rand_element());
        send_item(mrc_pkg::OP_FETCH, rand_element());
        wait_idle();
        write_size(rand_size());

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            count = 0;
            while (count < RANDOM_PER_PHASE) begin
                if ($urandom_range(99) < 35) begin
                    wait_idle();
                    write_size(rand_size());
                end
                total     = cur_side * cur_side;
                abandoned = 1'b0;
                for (k = 0; k < total && !abandoned; k++) begin
                    if ($urandom_range(99) < 8) begin
                        send_item(mrc_pkg::OP_FETCH, rand_element());
                        count++;
                    end
                    if (k > 0 && $urandom_range(99) < 3) begin
                        abandoned = 1'b1;
                    end else begin
                        send_item(mrc_pkg::OP_LOAD, rand_element());
                        count++;
                    end
                end
                if (abandoned) begin
                    wait_idle();
                    write_size(rand_size());
                end else begin
                    for (k = 0; k < total; k++) begin
                        if ($urandom_range(99) < 8) begin
                            send_item(mrc_pkg::OP_LOAD, rand_element());
                            count++;
                        end
                        send_item(mrc_pkg::OP_FETCH, rand_element());
                        count++;
                    end
                end
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < END_WAIT_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS matrix_rotate_ccw_unit");
        end else begin
            $display("FAIL matrix_rotate_ccw_unit");
        end
        $finish;
    end

endmodule
